>>> rtl/i2cmrt_pkg.sv
// shared types and constants for the i2c master register transfer unit
package i2cmrt_pkg;

    // command codes carried in the cmd field
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_WRITE = 2'd2;

    // configuration port
    localparam int unsigned CFG_ADDR_W = 3;
    localparam logic        REG_ACK_TIMEOUT = 1'b0;
    localparam logic [7:0]  ACK_TIMEOUT_RESET = 8'd250;

    // bus phases
    typedef enum logic [4:0] {
        PH_IDLE      = 5'd0,
        PH_START_A   = 5'd1,
        PH_START_B   = 5'd2,
        PH_SEND_ADRW = 5'd3,
        PH_ACK_ADRW  = 5'd4,
        PH_SEND_REG  = 5'd5,
        PH_ACK_REG   = 5'd6,
        PH_SEND_DATA = 5'd7,
        PH_ACK_DATA  = 5'd8,
        PH_RSTART_A  = 5'd9,
        PH_RSTART_B  = 5'd10,
        PH_SEND_ADRR = 5'd11,
        PH_ACK_ADRR  = 5'd12,
        PH_READ_BIT  = 5'd13,
        PH_ACK_BACK  = 5'd14,
        PH_STOP_A    = 5'd15,
        PH_STOP_B    = 5'd16,
        PH_STOP_C    = 5'd17
    } phase_t;

    // one input item: a timing tick with optional command
    typedef struct packed {
        logic [1:0] cmd;
        logic [6:0] dev_addr;
        logic [7:0] reg_addr;
        logic [7:0] xfer_len;
        logic [7:0] wr_data;
        logic       sda_in;
    } in_item_t;

    // one result item: pin levels and status after the tick
    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       sda_drive;
        logic       rd_valid;
        logic [7:0] rd_byte;
        logic       wr_request;
        logic       busy_res;
        logic       done_res;
        logic       ack_error;
        logic [7:0] bytes_done;
    } out_item_t;

endpackage

>>> rtl/i2c_master_register_transfer_unit.sv
// i2c master register transfer unit: pin-level sequencer, one bus tick per item
// each result is registered on the edge that accepts its item
// one item per cycle unless a held result stalls; one phase step per item
// a result waiting in the output register does not block the next item when taken
// reset: sequencer idle, pins high and driven, ack_timeout 250, output empty
module i2c_master_register_transfer_unit
    import i2cmrt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_item_t              in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_item_t             out_data,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    logic [7:0] ack_timeout_reg;

    phase_t     phase_reg, phase_next;
    logic [2:0] tick_reg, tick_next;
    logic [2:0] bit_index_reg, bit_index_next;
    logic [7:0] shift_reg, shift_next;
    logic [7:0] byte_count_reg, byte_count_next;
    logic [7:0] ack_wait_reg, ack_wait_next;
    logic [6:0] dev_reg, dev_next;
    logic [7:0] regaddr_reg, regaddr_next;
    logic [7:0] len_reg, len_next;
    logic       is_read_reg, is_read_next;
    logic       abort_reg, abort_next;
    logic       scl_reg, scl_next;
    logic       sda_reg, sda_next;
    logic       drv_reg, drv_next;

    logic       out_valid_reg;
    out_item_t  out_data_reg;

    logic       accept;
    logic       start_cmd;
    logic       ack_phase;
    logic       rd_valid_c;
    logic       wr_req_c;
    logic       busy_c;
    logic       done_c;
    logic       aerr_c;

    // configuration port
    assign pready = 1'b1;
    assign prdata = (paddr[CFG_ADDR_W-1] == REG_ACK_TIMEOUT) ? {24'd0, ack_timeout_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ack_timeout_reg <= ACK_TIMEOUT_RESET;
        end
        else if (psel && penable && pwrite && (paddr[CFG_ADDR_W-1] == REG_ACK_TIMEOUT))
        begin
            ack_timeout_reg <= pwdata[7:0];
        end
    end

    // handshake: take a new item whenever the output register frees up
    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign start_cmd = (in_data.cmd == CMD_READ) || (in_data.cmd == CMD_WRITE);
    assign ack_phase = (phase_reg == PH_ACK_ADRW) || (phase_reg == PH_ACK_REG)
                    || (phase_reg == PH_ACK_DATA) || (phase_reg == PH_ACK_ADRR);

    // next state of the sequencer for one tick
    always_comb
    begin
        phase_next      = phase_reg;
        tick_next       = tick_reg;
        bit_index_next  = bit_index_reg;
        shift_next      = shift_reg;
        byte_count_next = byte_count_reg;
        ack_wait_next   = ack_wait_reg;
        dev_next        = dev_reg;
        regaddr_next    = regaddr_reg;
        len_next        = len_reg;
        is_read_next    = is_read_reg;
        abort_next      = abort_reg;
        scl_next        = scl_reg;
        sda_next        = sda_reg;
        drv_next        = drv_reg;

        // command taken only while idle
        if (phase_reg == PH_IDLE)
        begin
            if (start_cmd)
            begin
                dev_next        = in_data.dev_addr;
                regaddr_next    = in_data.reg_addr;
                len_next        = in_data.xfer_len;
                is_read_next    = (in_data.cmd == CMD_READ);
                byte_count_next = 8'd0;
                abort_next      = 1'b0;
                ack_wait_next   = 8'd0;
                phase_next      = PH_START_A;
                tick_next       = 3'd0;
            end
            else
            begin
                {scl_next, sda_next, drv_next} = 3'b111;
            end
        end

        unique case (phase_next)
            PH_IDLE:
            begin
            end
            PH_START_A, PH_RSTART_A:
            begin
                {scl_next, sda_next, drv_next} = 3'b111;
                if (tick_next >= 3'd3)
                begin
                    phase_next = (phase_next == PH_START_A) ? PH_START_B : PH_RSTART_B;
                    tick_next  = 3'd0;
                end
                else
                begin
                    tick_next = tick_next + 3'd1;
                end
            end
            PH_START_B, PH_RSTART_B:
            begin
                {scl_next, sda_next, drv_next} = 3'b101;
                if (tick_next >= 3'd3)
                begin
                    tick_next      = 3'd0;
                    bit_index_next = 3'd7;
                    if (phase_next == PH_START_B)
                    begin
                        phase_next = PH_SEND_ADRW;
                        shift_next = {dev_next, 1'b0};
                    end
                    else
                    begin
                        phase_next = PH_SEND_ADRR;
                        shift_next = {dev_next, 1'b1};
                    end
                end
                else
                begin
                    tick_next = tick_next + 3'd1;
                end
            end
            PH_SEND_ADRW, PH_SEND_REG, PH_SEND_DATA, PH_SEND_ADRR:
            begin
                scl_next = (tick_next == 3'd2) || (tick_next == 3'd3);
                sda_next = shift_next[bit_index_next];
                drv_next = 1'b1;
                if (tick_next >= 3'd5)
                begin
                    tick_next = 3'd0;
                    if (bit_index_next == 3'd0)
                    begin
                        ack_wait_next = 8'd0;
                        unique case (phase_next)
                            PH_SEND_ADRW: phase_next = PH_ACK_ADRW;
                            PH_SEND_REG:  phase_next = PH_ACK_REG;
                            PH_SEND_DATA: phase_next = PH_ACK_DATA;
                            default:      phase_next = PH_ACK_ADRR;
                        endcase
                    end
                    else
                    begin
                        bit_index_next = bit_index_next - 3'd1;
                    end
                end
                else
                begin
                    tick_next = tick_next + 3'd1;
                end
            end
            PH_ACK_ADRW, PH_ACK_REG, PH_ACK_DATA, PH_ACK_ADRR:
            begin
                drv_next = 1'b0;
                sda_next = 1'b1;
                if (tick_next == 3'd0)
                begin
                    scl_next  = 1'b0;
                    tick_next = 3'd1;
                end
                else if (tick_next == 3'd1)
                begin
                    scl_next  = 1'b1;
                    tick_next = 3'd2;
                end
                else if (!in_data.sda_in)
                begin
                    // acknowledge seen
                    scl_next  = 1'b0;
                    tick_next = 3'd0;
                    unique case (phase_next)
                        PH_ACK_ADRW:
                        begin
                            phase_next     = PH_SEND_REG;
                            shift_next     = regaddr_next;
                            bit_index_next = 3'd7;
                        end
                        PH_ACK_REG:
                        begin
                            if (is_read_next)
                            begin
                                phase_next = PH_RSTART_A;
                            end
                            else if (len_next == 8'd0)
                            begin
                                phase_next = PH_STOP_A;
                            end
                            else
                            begin
                                phase_next     = PH_SEND_DATA;
                                shift_next     = in_data.wr_data;
                                bit_index_next = 3'd7;
                            end
                        end
                        PH_ACK_DATA:
                        begin
                            byte_count_next = byte_count_next + 8'd1;
                            if (byte_count_next == len_next)
                            begin
                                phase_next = PH_STOP_A;
                            end
                            else
                            begin
                                phase_next     = PH_SEND_DATA;
                                shift_next     = in_data.wr_data;
                                bit_index_next = 3'd7;
                            end
                        end
                        default:
                        begin
                            if (len_next == 8'd0)
                            begin
                                phase_next = PH_STOP_A;
                            end
                            else
                            begin
                                phase_next     = PH_READ_BIT;
                                shift_next     = 8'd0;
                                bit_index_next = 3'd7;
                            end
                        end
                    endcase
                end
                else if (ack_wait_next >= ack_timeout_reg)
                begin
                    // acknowledge timed out
                    scl_next   = 1'b1;
                    abort_next = 1'b1;
                    phase_next = PH_STOP_A;
                    tick_next  = 3'd0;
                end
                else
                begin
                    scl_next      = 1'b1;
                    ack_wait_next = ack_wait_next + 8'd1;
                end
            end
            PH_READ_BIT:
            begin
                drv_next = 1'b0;
                sda_next = 1'b1;
                if (tick_next < 3'd2)
                begin
                    scl_next  = 1'b0;
                    tick_next = tick_next + 3'd1;
                end
                else
                begin
                    scl_next   = 1'b1;
                    shift_next = {shift_next[6:0], in_data.sda_in};
                    tick_next  = 3'd0;
                    if (bit_index_next == 3'd0)
                    begin
                        phase_next = PH_ACK_BACK;
                    end
                    else
                    begin
                        bit_index_next = bit_index_next - 3'd1;
                    end
                end
            end
            PH_ACK_BACK:
            begin
                // nack on the last byte
                scl_next = (tick_next >= 3'd2);
                sda_next = (({1'b0, byte_count_next} + 9'd1) == {1'b0, len_next});
                drv_next = 1'b1;
                if (tick_next >= 3'd3)
                begin
                    byte_count_next = byte_count_next + 8'd1;
                    tick_next       = 3'd0;
                    if (byte_count_next == len_next)
                    begin
                        phase_next = PH_STOP_A;
                    end
                    else
                    begin
                        phase_next     = PH_READ_BIT;
                        shift_next     = 8'd0;
                        bit_index_next = 3'd7;
                    end
                end
                else
                begin
                    tick_next = tick_next + 3'd1;
                end
            end
            PH_STOP_A:
            begin
                {scl_next, sda_next, drv_next} = 3'b001;
                if (tick_next >= 3'd3)
                begin
                    phase_next = PH_STOP_B;
                    tick_next  = 3'd0;
                end
                else
                begin
                    tick_next = tick_next + 3'd1;
                end
            end
            PH_STOP_B:
            begin
                {scl_next, sda_next, drv_next} = 3'b101;
                if (tick_next >= 3'd3)
                begin
                    phase_next = PH_STOP_C;
                    tick_next  = 3'd0;
                end
                else
                begin
                    tick_next = tick_next + 3'd1;
                end
            end
            PH_STOP_C:
            begin
                {scl_next, sda_next, drv_next} = 3'b111;
                phase_next = PH_IDLE;
                tick_next  = 3'd0;
            end
            default:
            begin
                {scl_next, sda_next, drv_next} = 3'b111;
                phase_next = PH_IDLE;
                tick_next  = 3'd0;
            end
        endcase
    end

    // per-tick status flags
    always_comb
    begin
        rd_valid_c = (phase_reg == PH_ACK_BACK) && (tick_reg >= 3'd3);
        wr_req_c   = 1'b0;
        if (ack_phase && (tick_reg >= 3'd2) && !in_data.sda_in)
        begin
            if (phase_reg == PH_ACK_REG)
            begin
                wr_req_c = !is_read_reg && (len_reg != 8'd0);
            end
            else if (phase_reg == PH_ACK_DATA)
            begin
                wr_req_c = ((byte_count_reg + 8'd1) != len_reg);
            end
        end
        done_c = (phase_reg == PH_STOP_C);
        aerr_c = done_c && abort_reg;
        busy_c = 1'b1;
        if (phase_reg == PH_IDLE)
        begin
            busy_c = start_cmd;
        end
        else if (phase_reg > PH_STOP_C)
        begin
            busy_c = 1'b0;
        end
    end

    // sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            tick_reg       <= 3'd0;
            bit_index_reg  <= 3'd7;
            shift_reg      <= 8'd0;
            byte_count_reg <= 8'd0;
            ack_wait_reg   <= 8'd0;
            dev_reg        <= 7'd0;
            regaddr_reg    <= 8'd0;
            len_reg        <= 8'd1;
            is_read_reg    <= 1'b0;
            abort_reg      <= 1'b0;
            scl_reg        <= 1'b1;
            sda_reg        <= 1'b1;
            drv_reg        <= 1'b1;
        end
        else if (accept)
        begin
            phase_reg      <= phase_next;
            tick_reg       <= tick_next;
            bit_index_reg  <= bit_index_next;
            shift_reg      <= shift_next;
            byte_count_reg <= byte_count_next;
            ack_wait_reg   <= ack_wait_next;
            dev_reg        <= dev_next;
            regaddr_reg    <= regaddr_next;
            len_reg        <= len_next;
            is_read_reg    <= is_read_next;
            abort_reg      <= abort_next;
            scl_reg        <= scl_next;
            sda_reg        <= sda_next;
            drv_reg        <= drv_next;
        end
    end

    // output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg.scl_level  <= scl_next;
            out_data_reg.sda_level  <= sda_next;
            out_data_reg.sda_drive  <= drv_next;
            out_data_reg.rd_valid   <= rd_valid_c;
            out_data_reg.rd_byte    <= rd_valid_c ? shift_reg : 8'd0;
            out_data_reg.wr_request <= wr_req_c;
            out_data_reg.busy_res   <= busy_c;
            out_data_reg.done_res   <= done_c;
            out_data_reg.ack_error  <= aerr_c;
            out_data_reg.bytes_done <= byte_count_next;
        end
    end

    // checks
    a_stop_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (phase_reg == PH_STOP_C) |=> (phase_reg == PH_IDLE))
        else $error("sequencer did not return to idle after stop");

    a_accept_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid_reg)
        else $error("accepted transfer produced no result");

    a_idle_tick_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (phase_reg == PH_IDLE) && !start_cmd |=> !out_data_reg.busy_res)
        else $error("idle tick reported busy");

    a_error_with_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg.ack_error |-> out_data_reg.done_res)
        else $error("ack error reported without done");

    a_tick_range: assert property (@(posedge clk) disable iff (!rst_n)
        tick_reg <= 3'd5)
        else $error("tick counter out of range");

endmodule

>>> bench/i2cmrt_bus_checker.sv
// bus sequencer predictor and result checker for the i2c master register transfer unit
module i2cmrt_bus_checker
    import i2cmrt_pkg::*;
#(
    parameter logic [CFG_ADDR_W-1:0] TIMEOUT_ADDR = '0
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_ready,
    input  in_item_t              in_data,
    input  logic                  out_valid,
    input  logic                  out_ready,
    input  out_item_t             out_data,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    input  logic [31:0]           prdata,
    input  logic                  pready,
    output int unsigned           mismatch_count,
    output int unsigned           pending_results,
    output logic                  seq_idle
);

    // predicted sequencer state
    phase_t     ph;
    logic [2:0] tick_q;
    logic [2:0] bit_q;
    logic [7:0] shift_q;
    logic [7:0] count_q;
    logic [7:0] poll_q;
    logic [6:0] dev_q;
    logic [7:0] target_q;
    logic [7:0] len_q;
    logic       read_q;
    logic       abort_q;
    logic       scl_q;
    logic       sda_q;
    logic       drv_q;
    logic [7:0] timeout_q;

    // expected per-tick results, oldest first
    out_item_t   predicted_ticks[$];
    out_item_t   oldest;
    int unsigned bad_count = 0;
    int unsigned queued = 0;
    logic        idle_now = 1'b1;

    assign mismatch_count  = bad_count;
    assign pending_results = queued;
    assign seq_idle        = idle_now;

    function automatic void clear_sequencer();
        ph        = PH_IDLE;
        tick_q    = 3'd0;
        bit_q     = 3'd7;
        shift_q   = 8'd0;
        count_q   = 8'd0;
        poll_q    = 8'd0;
        dev_q     = 7'd0;
        target_q  = 8'd0;
        len_q     = 8'd1;
        read_q    = 1'b0;
        abort_q   = 1'b0;
        scl_q     = 1'b1;
        sda_q     = 1'b1;
        drv_q     = 1'b1;
        timeout_q = ACK_TIMEOUT_RESET;
    endfunction

    function automatic void set_pins(input logic scl, input logic sda, input logic drv);
        scl_q = scl;
        sda_q = sda;
        drv_q = drv;
    endfunction

    function automatic void go_phase(input phase_t p);
        ph     = p;
        tick_q = 3'd0;
    endfunction

    function automatic void load_shift(input phase_t p, input logic [7:0] value);
        go_phase(p);
        shift_q = value;
        bit_q   = 3'd7;
    endfunction

    function automatic void begin_read();
        go_phase(PH_READ_BIT);
        shift_q = 8'd0;
        bit_q   = 3'd7;
    endfunction

    // one bus tick: advance the sequencer and build the result it reports
    function automatic out_item_t advance_bus(input in_item_t it);
        out_item_t r;
        r          = '0;
        r.busy_res = 1'b1;

        // idle: a read or write command latches its fields
        if (ph == PH_IDLE)
        begin
            if (it.cmd == CMD_READ || it.cmd == CMD_WRITE)
            begin
                dev_q    = it.dev_addr;
                target_q = it.reg_addr;
                len_q    = it.xfer_len;
                read_q   = (it.cmd == CMD_READ);
                count_q  = 8'd0;
                abort_q  = 1'b0;
                poll_q   = 8'd0;
                go_phase(PH_START_A);
            end
            else
            begin
                r.busy_res = 1'b0;
                set_pins(1'b1, 1'b1, 1'b1);
            end
        end

        case (ph)
            PH_IDLE:
            begin
            end
            // start and repeated start: both lines high, then sda low
            PH_START_A, PH_RSTART_A:
            begin
                set_pins(1'b1, 1'b1, 1'b1);
                if (tick_q >= 3'd3)
                    go_phase(phase_t'(ph + 5'd1));
                else
                    tick_q = tick_q + 3'd1;
            end
            PH_START_B, PH_RSTART_B:
            begin
                set_pins(1'b1, 1'b0, 1'b1);
                if (tick_q >= 3'd3)
                begin
                    if (ph == PH_START_B)
                        load_shift(PH_SEND_ADRW, {dev_q, 1'b0});
                    else
                        load_shift(PH_SEND_ADRR, {dev_q, 1'b1});
                end
                else
                    tick_q = tick_q + 3'd1;
            end
            // shift out one byte, msb first, six ticks per bit
            PH_SEND_ADRW, PH_SEND_REG, PH_SEND_DATA, PH_SEND_ADRR:
            begin
                set_pins(tick_q == 3'd2 || tick_q == 3'd3, shift_q[bit_q], 1'b1);
                if (tick_q >= 3'd5)
                begin
                    if (bit_q == 3'd0)
                    begin
                        go_phase(phase_t'(ph + 5'd1));
                        poll_q = 8'd0;
                    end
                    else
                    begin
                        bit_q  = bit_q - 3'd1;
                        tick_q = 3'd0;
                    end
                end
                else
                    tick_q = tick_q + 3'd1;
            end
            // slave acknowledge poll with timeout
            PH_ACK_ADRW, PH_ACK_REG, PH_ACK_DATA, PH_ACK_ADRR:
            begin
                if (tick_q == 3'd0)
                begin
                    set_pins(1'b0, 1'b1, 1'b0);
                    tick_q = 3'd1;
                end
                else if (tick_q == 3'd1)
                begin
                    set_pins(1'b1, 1'b1, 1'b0);
                    tick_q = 3'd2;
                end
                else if (!it.sda_in)
                begin
                    set_pins(1'b0, 1'b1, 1'b0);
                    case (ph)
                        PH_ACK_ADRW:
                            load_shift(PH_SEND_REG, target_q);
                        PH_ACK_REG:
                        begin
                            if (read_q)
                                go_phase(PH_RSTART_A);
                            else if (len_q == 8'd0)
                                go_phase(PH_STOP_A);
                            else
                            begin
                                r.wr_request = 1'b1;
                                load_shift(PH_SEND_DATA, it.wr_data);
                            end
                        end
                        PH_ACK_DATA:
                        begin
                            count_q = count_q + 8'd1;
                            if (count_q == len_q)
                                go_phase(PH_STOP_A);
                            else
                            begin
                                r.wr_request = 1'b1;
                                load_shift(PH_SEND_DATA, it.wr_data);
                            end
                        end
                        default:
                        begin
                            if (len_q == 8'd0)
                                go_phase(PH_STOP_A);
                            else
                                begin_read();
                        end
                    endcase
                end
                else if (poll_q >= timeout_q)
                begin
                    set_pins(1'b1, 1'b1, 1'b0);
                    abort_q = 1'b1;
                    go_phase(PH_STOP_A);
                end
                else
                begin
                    set_pins(1'b1, 1'b1, 1'b0);
                    poll_q = poll_q + 8'd1;
                end
            end
            // sample one data bit on the high scl tick
            PH_READ_BIT:
            begin
                if (tick_q < 3'd2)
                begin
                    set_pins(1'b0, 1'b1, 1'b0);
                    tick_q = tick_q + 3'd1;
                end
                else
                begin
                    set_pins(1'b1, 1'b1, 1'b0);
                    shift_q = {shift_q[6:0], it.sda_in};
                    if (bit_q == 3'd0)
                        go_phase(PH_ACK_BACK);
                    else
                    begin
                        bit_q  = bit_q - 3'd1;
                        tick_q = 3'd0;
                    end
                end
            end
            // master ack, nack on the last byte, byte presented at the end
            PH_ACK_BACK:
            begin
                set_pins(tick_q >= 3'd2, ({1'b0, count_q} + 9'd1) == {1'b0, len_q}, 1'b1);
                if (tick_q >= 3'd3)
                begin
                    count_q    = count_q + 8'd1;
                    r.rd_valid = 1'b1;
                    r.rd_byte  = shift_q;
                    if (count_q == len_q)
                        go_phase(PH_STOP_A);
                    else
                        begin_read();
                end
                else
                    tick_q = tick_q + 3'd1;
            end
            // stop condition
            PH_STOP_A:
            begin
                set_pins(1'b0, 1'b0, 1'b1);
                if (tick_q >= 3'd3)
                    go_phase(PH_STOP_B);
                else
                    tick_q = tick_q + 3'd1;
            end
            PH_STOP_B:
            begin
                set_pins(1'b1, 1'b0, 1'b1);
                if (tick_q >= 3'd3)
                    go_phase(PH_STOP_C);
                else
                    tick_q = tick_q + 3'd1;
            end
            PH_STOP_C:
            begin
                set_pins(1'b1, 1'b1, 1'b1);
                r.done_res  = 1'b1;
                r.ack_error = abort_q;
                go_phase(PH_IDLE);
            end
            default:
            begin
                set_pins(1'b1, 1'b1, 1'b1);
                go_phase(PH_IDLE);
                r.busy_res = 1'b0;
            end
        endcase

        r.scl_level  = scl_q;
        r.sda_level  = sda_q;
        r.sda_drive  = drv_q;
        r.bytes_done = count_q;
        return r;
    endfunction

    function automatic bit field_bad(input string name, input logic [7:0] want,
                                     input logic [7:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic bit result_differs(input out_item_t want, input out_item_t got);
        bit bad;
        bad = 1'b0;
        bad |= field_bad("scl_level", 8'(want.scl_level), 8'(got.scl_level));
        bad |= field_bad("sda_level", 8'(want.sda_level), 8'(got.sda_level));
        bad |= field_bad("sda_drive", 8'(want.sda_drive), 8'(got.sda_drive));
        bad |= field_bad("rd_valid", 8'(want.rd_valid), 8'(got.rd_valid));
        bad |= field_bad("rd_byte", want.rd_byte, got.rd_byte);
        bad |= field_bad("wr_request", 8'(want.wr_request), 8'(got.wr_request));
        bad |= field_bad("busy_res", 8'(want.busy_res), 8'(got.busy_res));
        bad |= field_bad("done_res", 8'(want.done_res), 8'(got.done_res));
        bad |= field_bad("ack_error", 8'(want.ack_error), 8'(got.ack_error));
        bad |= field_bad("bytes_done", want.bytes_done, got.bytes_done);
        return bad;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_sequencer();
            predicted_ticks.delete();
        end
        else
        begin
            // register writes update the timeout, reads must return it
            if (psel && penable && pready && paddr == TIMEOUT_ADDR)
            begin
                if (pwrite)
                    timeout_q = pwdata[7:0];
                else if (prdata !== {24'h0, timeout_q})
                begin
                    $display("%0t: ack_timeout readback expected %0h actual %0h",
                             $time, {24'h0, timeout_q}, prdata);
                    bad_count = bad_count + 1;
                end
            end

            // input transfer: predict the tick
            if (in_valid && in_ready)
                predicted_ticks.push_back(advance_bus(in_data));

            // result transfer: compare with the oldest prediction
            if (out_valid && out_ready)
            begin
                if (predicted_ticks.size() == 0)
                begin
                    $display("%0t: result expected none actual %h", $time, out_data);
                    bad_count = bad_count + 1;
                end
                else
                begin
                    oldest = predicted_ticks.pop_front();
                    if (result_differs(oldest, out_data))
                        bad_count = bad_count + 1;
                end
            end
        end
        queued   = predicted_ticks.size();
        idle_now = (ph == PH_IDLE);
    end

endmodule

>>> bench/i2c_master_register_transfer_unit_test.sv
// stimulus and verdict for the i2c master register transfer unit
module i2c_master_register_transfer_unit_test
    import i2cmrt_pkg::*;
();

    localparam logic [1:0]            CMD_UNUSED   = 2'd3;
    localparam logic [CFG_ADDR_W-1:0] TIMEOUT_ADDR = CFG_ADDR_W'(4 * REG_ACK_TIMEOUT);
    localparam int unsigned           CYCLE_LIMIT  = 400000;
    localparam int unsigned           LONG_STALL   = 60;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    in_item_t              in_data = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    out_item_t             out_data;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [31:0]           pwdata = '0;
    logic [31:0]           prdata;
    logic                  pready;

    int unsigned mismatch_count;
    int unsigned pending_results;
    logic        seq_idle;

    int unsigned cycle_count = 0;
    int unsigned send_idle_pct = 38;
    int unsigned recv_idle_pct = 48;
    int unsigned stall_req = 0;
    int unsigned stall_served = 0;
    int unsigned stall_left = 0;

    i2c_master_register_transfer_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    i2cmrt_bus_checker #(.TIMEOUT_ADDR(TIMEOUT_ADDR)) bus_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .in_data         (in_data),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .out_data        (out_data),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .mismatch_count  (mismatch_count),
        .pending_results (pending_results),
        .seq_idle        (seq_idle)
    );

    always #6 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // result side: random stalls, plus long hold-offs on request
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (stall_served != stall_req)
        begin
            out_ready    <= 1'b0;
            stall_left   <= LONG_STALL - 1;
            stall_served <= stall_served + 1;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // one bus tick with random fields; sda low with the given odds
    function automatic in_item_t tick_item(input logic [1:0] code, input int unsigned low_pct);
        in_item_t it;
        it.cmd      = code;
        it.dev_addr = 7'($urandom);
        it.reg_addr = 8'($urandom);
        it.xfer_len = 8'($urandom);
        it.wr_data  = 8'($urandom);
        it.sda_in   = ($urandom_range(99) < low_pct) ? 1'b0 : 1'b1;
        return it;
    endfunction

    // offer one item and hold it until the transfer
    task automatic send_item(input in_item_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic ticks(input int n, input int unsigned low_pct);
        repeat (n)
            send_item(tick_item(CMD_TICK, low_pct));
    endtask

    task automatic command(input logic [1:0] code, input logic [6:0] dev,
                           input logic [7:0] target, input logic [7:0] len);
        in_item_t it;
        it          = tick_item(code, 50);
        it.dev_addr = dev;
        it.reg_addr = target;
        it.xfer_len = len;
        send_item(it);
    endtask

    // stop offering until every result is back
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        wait (pending_results == 0);
    endtask

    // run the sequencer out to idle with random sda
    task automatic settle();
        drain();
        while (!seq_idle)
        begin
            ticks(16, 50);
            drain();
        end
    endtask

    task automatic apb_access(input logic wr, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= TIMEOUT_ADDR;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_timeout(input logic [7:0] value);
        settle();
        apb_access(1'b1, {24'h0, value});
        apb_access(1'b0, 32'h0);
    endtask

    // mostly short register accesses with random payload and sda styles
    task automatic random_items(input int n, input int stall_at, input int pause_at);
        in_item_t    it;
        int unsigned roll;
        int unsigned low_pct;
        low_pct = 50;
        for (int i = 0; i < n; i++)
        begin
            if (i == stall_at)
                stall_req <= stall_req + 1;
            if (i == pause_at)
                drain();
            roll = $urandom_range(99);
            if (roll < 4)
                it = tick_item(CMD_READ, low_pct);
            else if (roll < 8)
                it = tick_item(CMD_WRITE, low_pct);
            else if (roll < 10)
                it = tick_item(CMD_UNUSED, low_pct);
            else
                it = tick_item(CMD_TICK, low_pct);
            if (it.cmd == CMD_READ || it.cmd == CMD_WRITE)
            begin
                if ($urandom_range(9) == 0)
                    it.xfer_len = 8'($urandom_range(8, 4));
                else
                    it.xfer_len = 8'($urandom_range(3, 0));
                roll = $urandom_range(99);
                if (roll < 60)
                    low_pct = 50;
                else if (roll < 85)
                    low_pct = 85;
                else if (roll < 95)
                    low_pct = 100;
                else
                    low_pct = 10;
            end
            send_item(it);
        end
    endtask

    initial
    begin
        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero-length write with prompt acks, a command lands on its done tick
        command(CMD_WRITE, 7'h7F, 8'hFF, 8'h00);
        ticks(117, 100);
        command(CMD_WRITE, 7'h00, 8'h00, 8'h01);

        // unused code at idle, zero-length read with a command while busy
        command(CMD_UNUSED, 7'h00, 8'h00, 8'h01);
        command(CMD_READ, 7'h00, 8'h00, 8'h00);
        ticks(30, 100);
        command(CMD_WRITE, 7'h7F, 8'hFF, 8'h02);
        ticks(146, 100);
        settle();

        // timeout of zero: abort on the first high poll
        set_timeout(8'd0);
        command(CMD_WRITE, 7'h3C, 8'h0F, 8'h01);
        ticks(70, 0);
        settle();

        // longest timeout with sda stuck high
        set_timeout(8'd255);
        command(CMD_READ, 7'h12, 8'h34, 8'h01);
        ticks(330, 0);

        // random, sender idles less than receiver, one long result stall
        set_timeout(8'd3);
        random_items(60, 30, -1);

        // random, roles swapped, one pause until all results are back
        send_idle_pct = 48;
        recv_idle_pct <= 38;
        random_items(60, -1, 30);

        // random, no idling, another long result stall
        send_idle_pct = 0;
        recv_idle_pct <= 0;
        random_items(60, 30, -1);

        settle();
        repeat (20)
            @(posedge clk);
        if (mismatch_count == 0 && pending_results == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

>>> filelist.f
rtl/i2cmrt_pkg.sv
rtl/i2c_master_register_transfer_unit.sv
bench/i2cmrt_bus_checker.sv
bench/i2c_master_register_transfer_unit_test.sv
